@@ rtl/pnn_pkg.sv @@
// Package for the polygon normal unit: item structs, datapath op codes,
// controller/datapath command and status structs. No dependencies.
package pnn_pkg;

    localparam int SUM_BITS = 42;
    localparam int Q14_BITS = 15;
    localparam logic [Q14_BITS-1:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        vertex_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic               last_of_face;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } t_out_item;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FACE = 1'b1;

    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_LATCH      = 5'd1;
    localparam logic [4:0] OP_REDUCE     = 5'd2;
    localparam logic [4:0] OP_WRITE      = 5'd3;
    localparam logic [4:0] OP_READ       = 5'd4;
    localparam logic [4:0] OP_OPEN       = 5'd5;
    localparam logic [4:0] OP_EDGE_OPEN  = 5'd6;
    localparam logic [4:0] OP_EDGE_CLOSE = 5'd7;
    localparam logic [4:0] OP_MUL        = 5'd8;
    localparam logic [4:0] OP_ACC        = 5'd9;
    localparam logic [4:0] OP_ABS        = 5'd10;
    localparam logic [4:0] OP_SHIFT      = 5'd11;
    localparam logic [4:0] OP_SQ         = 5'd12;
    localparam logic [4:0] OP_BS_INIT    = 5'd13;
    localparam logic [4:0] OP_T2         = 5'd14;
    localparam logic [4:0] OP_PLO        = 5'd15;
    localparam logic [4:0] OP_PHI        = 5'd16;
    localparam logic [4:0] OP_CMP        = 5'd17;
    localparam logic [4:0] OP_STORE      = 5'd18;
    localparam logic [4:0] OP_EMIT       = 5'd19;
    localparam logic [4:0] OP_EMIT_DEGEN = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_over;
        logic is_load;
        logic last;
        logic mag_zero;
        logic mag_big;
        logic lo_lt_hi;
        logic out_busy;
    } t_dp_status;

endpackage

@@ rtl/polygon_normal_newell_unit.sv @@
// Top level of the polygon normal unit: joins pnn_ctrl and pnn_datapath.
// Uses pnn_pkg.
//
// One item at a time. A load latches, checks the index and writes the memory.
// A face vertex that opens a face latches, checks the index, reads the memory
// and checks for the face end. Any later face vertex takes the memory read,
// then three multiply/accumulate pairs on one shared multiplier. Indexes at or
// above VERTEX_COUNT add one reduce step per subtraction of VERTEX_COUNT. A
// closing vertex then does the closing edge and the magnitudes, up to 26
// normalizing shifts plus one check, and 3 squares. Each component then takes
// a binary search of up to 15 steps, plus setup and store. The emit follows. A
// degenerate face goes from the magnitude check straight to the emit. The result
// sits in an output register, so the next items are taken while it waits. The
// next closing vertex stalls until that result is taken.
module polygon_normal_newell_unit #(
    parameter int VERTEX_COUNT   = 4096,
    parameter int COORD_BITS     = 16,
    parameter int MAX_FACE_VERTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pnn_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pnn_pkg::t_out_item o_out_item
);
    import pnn_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pnn_ctrl #(
        .MAX_FACE_VERTS(MAX_FACE_VERTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pnn_datapath #(
        .VERTEX_COUNT(VERTEX_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/pnn_datapath.sv @@
// Datapath of the polygon normal unit: vertex memory, edge multiplier,
// accumulators, normalization and binary-search divider. Uses pnn_pkg.
module pnn_datapath #(
    parameter int VERTEX_COUNT = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pnn_pkg::t_in_item   i_in_item,
    input  logic                i_out_ready,
    input  pnn_pkg::t_dp_cmd    i_cmd,
    output pnn_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output pnn_pkg::t_out_item  o_out_item
);
    import pnn_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int IW = ((AW > 12) ? AW : 12) + 1;
    localparam int PW = 2 * CB + 2;
    localparam int EW = (PW > SUM_BITS) ? PW : SUM_BITS;

    logic [3*CB-1:0] mem [VERTEX_COUNT];

    logic [IW-1:0]              r_idx;
    logic                       r_cmd;
    logic                       r_last;
    logic [2:0][CB-1:0]         r_coord;
    logic [3*CB-1:0]            r_rdata;
    logic [2:0][CB-1:0]         r_first;
    logic [2:0][CB-1:0]         r_prev;
    logic [2:0][CB-1:0]         r_a;
    logic [2:0][CB-1:0]         r_b;
    logic signed [PW-1:0]       r_prod;
    logic [2:0][SUM_BITS-1:0]   r_sum;
    logic [2:0][SUM_BITS-1:0]   r_mag;
    logic [2:0][31:0]           r_a2;
    logic [33:0]                r_s;
    logic [Q14_BITS-1:0]        r_lo;
    logic [Q14_BITS-1:0]        r_hi;
    logic [29:0]                r_t2;
    logic [46:0]                r_plo;
    logic [46:0]                r_phi;
    logic [2:0][15:0]           r_norm;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic signed [CB:0]         w_d;
    logic signed [CB:0]         w_s;
    logic signed [EW-1:0]       w_pext;
    logic [Q14_BITS-1:0]        w_mid;
    logic [15:0]                w_t;
    logic [31:0]                w_t2;
    logic [31:0]                w_sq;
    logic [64:0]                w_lhs;
    logic [64:0]                w_rhs;
    logic [2:0][CB-1:0]         w_rd;

    assign w_rd = r_rdata;

    always_comb begin
        case (i_cmd.axis)
            2'd0: begin
                w_d = (CB+1)'($signed(r_a[1])) - (CB+1)'($signed(r_b[1]));
                w_s = (CB+1)'($signed(r_a[2])) + (CB+1)'($signed(r_b[2]));
            end
            2'd1: begin
                w_d = (CB+1)'($signed(r_a[2])) - (CB+1)'($signed(r_b[2]));
                w_s = (CB+1)'($signed(r_a[0])) + (CB+1)'($signed(r_b[0]));
            end
            default: begin
                w_d = (CB+1)'($signed(r_a[0])) - (CB+1)'($signed(r_b[0]));
                w_s = (CB+1)'($signed(r_a[1])) + (CB+1)'($signed(r_b[1]));
            end
        endcase
    end

    assign w_pext = EW'(r_prod);
    assign w_mid  = Q14_BITS'((16'(r_lo) + 16'(r_hi) + 16'd1) >> 1);
    assign w_t    = 16'({w_mid, 1'b0}) - 16'd1;
    assign w_t2   = w_t * w_t;
    assign w_sq   = r_mag[i_cmd.axis][15:0] * r_mag[i_cmd.axis][15:0];
    assign w_lhs  = 65'({r_phi, 17'b0}) + 65'(r_plo);
    assign w_rhs  = 65'({r_a2[i_cmd.axis], 30'b0});

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_idx      <= IW'(i_in_item.vertex_index);
                r_cmd      <= i_in_item.cmd;
                r_last     <= i_in_item.last_of_face;
                r_coord[0] <= CB'(i_in_item.coord_x);
                r_coord[1] <= CB'(i_in_item.coord_y);
                r_coord[2] <= CB'(i_in_item.coord_z);
            end
            OP_REDUCE: r_idx <= r_idx - IW'(VERTEX_COUNT);
            OP_WRITE:  mem[r_idx[AW-1:0]] <= r_coord;
            OP_READ:   r_rdata <= mem[r_idx[AW-1:0]];
            OP_OPEN: begin
                r_first <= w_rd;
                r_prev  <= w_rd;
                r_sum   <= '0;
            end
            OP_EDGE_OPEN: begin
                r_a    <= r_prev;
                r_b    <= w_rd;
                r_prev <= w_rd;
            end
            OP_EDGE_CLOSE: begin
                r_a <= r_prev;
                r_b <= r_first;
            end
            OP_MUL: r_prod <= w_d * w_s;
            OP_ACC: r_sum[i_cmd.axis] <= r_sum[i_cmd.axis] + w_pext[SUM_BITS-1:0];
            OP_ABS: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= r_sum[k][SUM_BITS-1] ? -r_sum[k] : r_sum[k];
                end
            end
            OP_SHIFT: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= r_mag[k] >> 1;
                end
            end
            OP_SQ: begin
                r_a2[i_cmd.axis] <= w_sq;
                r_s <= ((i_cmd.axis == 2'd0) ? 34'd0 : r_s) + 34'(w_sq);
            end
            OP_BS_INIT: begin
                r_lo <= '0;
                r_hi <= ONE_Q14;
            end
            OP_T2:  r_t2  <= w_t2[29:0];
            OP_PLO: r_plo <= r_t2 * r_s[16:0];
            OP_PHI: r_phi <= r_t2 * r_s[33:17];
            OP_CMP: begin
                if (w_lhs <= w_rhs) begin
                    r_lo <= w_mid;
                end else begin
                    r_hi <= w_mid - Q14_BITS'(1);
                end
            end
            OP_STORE: begin
                r_norm[i_cmd.axis] <= r_sum[i_cmd.axis][SUM_BITS-1] ?
                    -16'(r_lo) : 16'(r_lo);
            end
            OP_EMIT: begin
                r_out.normal_x   <= r_norm[0];
                r_out.normal_y   <= r_norm[1];
                r_out.normal_z   <= r_norm[2];
                r_out.degenerate <= 1'b0;
            end
            OP_EMIT_DEGEN: begin
                r_out.normal_x   <= '0;
                r_out.normal_y   <= '0;
                r_out.normal_z   <= '0;
                r_out.degenerate <= 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT || i_cmd.op == OP_EMIT_DEGEN) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.idx_over = (r_idx >= IW'(VERTEX_COUNT));
    assign o_status.is_load  = (r_cmd == CMD_LOAD);
    assign o_status.last     = r_last;
    assign o_status.mag_zero = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
    assign o_status.mag_big  = (|r_mag[0][SUM_BITS-1:16]) || (|r_mag[1][SUM_BITS-1:16])
                            || (|r_mag[2][SUM_BITS-1:16]);
    assign o_status.lo_lt_hi = (r_lo < r_hi);
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/pnn_ctrl.sv @@
// Controller of the polygon normal unit: sequences load, edge accumulation,
// face closing and normalization. Uses pnn_pkg.
module pnn_ctrl #(
    parameter int MAX_FACE_VERTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pnn_pkg::t_dp_status i_status,
    output pnn_pkg::t_dp_cmd    o_cmd
);
    import pnn_pkg::*;

    localparam int CW = $clog2(MAX_FACE_VERTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_REDUCE = 5'd1;
    localparam logic [4:0] S_WRITE  = 5'd2;
    localparam logic [4:0] S_READ   = 5'd3;
    localparam logic [4:0] S_RDWAIT = 5'd4;
    localparam logic [4:0] S_CHECK  = 5'd5;
    localparam logic [4:0] S_MUL    = 5'd6;
    localparam logic [4:0] S_ACC    = 5'd7;
    localparam logic [4:0] S_ABS    = 5'd8;
    localparam logic [4:0] S_SHIFT  = 5'd9;
    localparam logic [4:0] S_SQ     = 5'd10;
    localparam logic [4:0] S_BSINIT = 5'd11;
    localparam logic [4:0] S_BSTEST = 5'd12;
    localparam logic [4:0] S_T2     = 5'd13;
    localparam logic [4:0] S_PLO    = 5'd14;
    localparam logic [4:0] S_PHI    = 5'd15;
    localparam logic [4:0] S_CMP    = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    logic [4:0]    r_state, n_state;
    logic [1:0]    r_axis, n_axis;
    logic          r_inside, n_inside;
    logic          r_closing, n_closing;
    logic          r_degen, n_degen;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= '0;
            r_inside  <= 1'b0;
            r_closing <= 1'b0;
            r_degen   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_inside  <= n_inside;
            r_closing <= n_closing;
            r_degen   <= n_degen;
            r_cnt     <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_axis    = r_axis;
        n_inside  = r_inside;
        n_closing = r_closing;
        n_degen   = r_degen;
        n_cnt     = r_cnt;
        o_cmd.op  = OP_NOP;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.idx_over) begin
                    o_cmd.op = OP_REDUCE;
                end else if (i_status.is_load) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                o_cmd.op = OP_WRITE;
                n_state  = S_IDLE;
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_state  = S_RDWAIT;
            end
            S_RDWAIT: begin
                if (!r_inside) begin
                    o_cmd.op = OP_OPEN;
                    n_inside = 1'b1;
                    n_cnt    = CW'(1);
                    n_state  = S_CHECK;
                end else begin
                    o_cmd.op  = OP_EDGE_OPEN;
                    n_cnt     = r_cnt + CW'(1);
                    n_closing = 1'b0;
                    n_axis    = '0;
                    n_state   = S_MUL;
                end
            end
            S_CHECK: begin
                if (i_status.last || r_cnt >= CW'(MAX_FACE_VERTS)) begin
                    o_cmd.op  = OP_EDGE_CLOSE;
                    n_closing = 1'b1;
                    n_axis    = '0;
                    n_state   = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_axis == 2'd2) begin
                    n_axis  = '0;
                    n_state = r_closing ? S_ABS : S_CHECK;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_ABS: begin
                o_cmd.op = OP_ABS;
                n_state  = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_status.mag_zero) begin
                    n_degen = 1'b1;
                    n_state = S_EMIT;
                end else if (i_status.mag_big) begin
                    o_cmd.op = OP_SHIFT;
                end else begin
                    n_degen = 1'b0;
                    n_axis  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (r_axis == 2'd2) begin
                    n_axis  = '0;
                    n_state = S_BSINIT;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            S_BSINIT: begin
                o_cmd.op = OP_BS_INIT;
                n_state  = S_BSTEST;
            end
            S_BSTEST: begin
                if (i_status.lo_lt_hi) begin
                    n_state = S_T2;
                end else begin
                    o_cmd.op = OP_STORE;
                    if (r_axis == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_BSINIT;
                    end
                end
            end
            S_T2: begin
                o_cmd.op = OP_T2;
                n_state  = S_PLO;
            end
            S_PLO: begin
                o_cmd.op = OP_PLO;
                n_state  = S_PHI;
            end
            S_PHI: begin
                o_cmd.op = OP_PHI;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = S_BSTEST;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = r_degen ? OP_EMIT_DEGEN : OP_EMIT;
                    n_inside = 1'b0;
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/pnn_checker.sv @@
// Port-level checks for polygon_normal_newell_unit, bound to the top level.
// Uses pnn_pkg.
module pnn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pnn_pkg::t_out_item o_out_item,
    input logic               o_out_valid,
    input logic               i_out_ready
);
    import pnn_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item taken while previous item still in work");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.degenerate |->
            o_out_item.normal_x == 16'sd0 && o_out_item.normal_y == 16'sd0
            && o_out_item.normal_z == 16'sd0)
        else $error("degenerate result with nonzero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_item.normal_x <= 16'sd16384 && o_out_item.normal_x >= -16'sd16384
            && o_out_item.normal_y <= 16'sd16384 && o_out_item.normal_y >= -16'sd16384
            && o_out_item.normal_z <= 16'sd16384 && o_out_item.normal_z >= -16'sd16384)
        else $error("normal component outside unit range");

endmodule

bind polygon_normal_newell_unit pnn_checker u_pnn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_item  (o_out_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for polygon_normal_newell_unit: loads vertices, streams faces and
// checks each emitted normal against an in-bench Newell predictor. Uses pnn_pkg.
module tb;
    import pnn_pkg::*;

    localparam int NVERT     = 4096;
    localparam int MAX_VERTS = 256;
    localparam int WD_LIMIT  = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    polygon_normal_newell_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] vx [NVERT];
    logic signed [15:0] vy [NVERT];
    logic signed [15:0] vz [NVERT];
    bit                 written [NVERT];
    logic signed [15:0] fx, fy, fz, px, py, pz;
    logic [41:0]        acc_x, acc_y, acc_z;
    bit                 face_open;
    int                 face_len;

    t_in_item  pending_items [$];
    t_out_item normals_due [$];
    int        errors = 0;
    bit        hold_rx = 0;

    function automatic logic [41:0] cross_term(logic signed [15:0] d0, logic signed [15:0] d1,
                                               logic signed [15:0] s0, logic signed [15:0] s1);
        logic signed [41:0] d, s;
        d = 42'(d0) - 42'(d1);
        s = 42'(s0) + 42'(s1);
        return d * s;
    endfunction

    task automatic add_edge(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, logic signed [15:0] bx,
                            logic signed [15:0] by, logic signed [15:0] bz);
        acc_x = acc_x + cross_term(ay, by, az, bz);
        acc_y = acc_y + cross_term(az, bz, ax, bx);
        acc_z = acc_z + cross_term(ax, bx, ay, by);
    endtask

    function automatic longint unsigned round_unit(longint unsigned a, longint unsigned s);
        longint unsigned lo, hi, mid, t, rhs;
        lo = 0;
        hi = 16384;
        rhs = (a * a) << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_out_item unit_normal(logic [41:0] sx, logic [41:0] sy,
                                              logic [41:0] sz);
        t_out_item r;
        logic signed [41:0] v [3];
        longint unsigned mag [3];
        longint unsigned m, s, n;
        int sh;
        logic [15:0] c [3];
        v[0] = sx;
        v[1] = sy;
        v[2] = sz;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? -longint'(v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        r = '0;
        if (m == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        sh = 0;
        while ((m >> sh) >= 65536) sh++;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] >> sh;
            s += mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            n = round_unit(mag[i], s);
            if (v[i] < 0) n = -n;
            c[i] = n[15:0];
        end
        r.normal_x = c[0];
        r.normal_y = c[1];
        r.normal_z = c[2];
        return r;
    endfunction

    task automatic predict_item(t_in_item it);
        logic signed [15:0] cx, cy, cz;
        if (it.cmd == CMD_LOAD) begin
            vx[it.vertex_index] = it.coord_x;
            vy[it.vertex_index] = it.coord_y;
            vz[it.vertex_index] = it.coord_z;
            return;
        end
        cx = vx[it.vertex_index];
        cy = vy[it.vertex_index];
        cz = vz[it.vertex_index];
        if (!face_open) begin
            {fx, fy, fz} = {cx, cy, cz};
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
            face_open = 1;
            face_len = 1;
        end else begin
            add_edge(px, py, pz, cx, cy, cz);
            face_len++;
        end
        {px, py, pz} = {cx, cy, cz};
        if (it.last_of_face || face_len >= MAX_VERTS) begin
            add_edge(cx, cy, cz, fx, fy, fz);
            normals_due.push_back(unit_normal(acc_x, acc_y, acc_z));
            face_open = 0;
            face_len = 0;
        end
    endtask

    // stimulus builders: stimulus-side record of written entries
    int loaded [$];

    task automatic queue_load(int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_in_item it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.vertex_index = idx[11:0];
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.last_of_face = 1'($urandom_range(0, 1));
        if (!written[idx]) loaded.push_back(idx);
        written[idx] = 1;
        pending_items.push_back(it);
    endtask

    task automatic queue_face_vertex(int idx, bit last);
        t_in_item it;
        it = '0;
        it.cmd = CMD_FACE;
        it.vertex_index = idx[11:0];
        it.coord_x = 16'($urandom);
        it.coord_y = 16'($urandom);
        it.coord_z = 16'($urandom);
        it.last_of_face = last;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_face(int n);
        for (int i = 0; i < n; i++)
            queue_face_vertex(loaded[$urandom_range(0, loaded.size() - 1)], i == n - 1);
    endtask

    // acceptance seen at the rising edge
    logic in_ready_q = 1'b0;

    // driver
    int gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready_q) begin
                if (pending_items.size() > 0 && gap == 0) begin
                    in_item <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid) begin
                if (gap > 0) gap <= gap - 1;
                else if (pending_items.size() > 0) begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
            end
            if (in_valid && in_ready_q)
                gap <= ($urandom_range(0, 9) < 6) ? 0 :
                       ($urandom_range(0, 19) == 0 ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4));
        end
    end

    int   idle_cycles = 0;
    always @(posedge clk) begin
        in_ready_q <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready) predict_item(in_item);
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("polygon_normal_newell_unit test failed");
            $finish;
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (normals_due.size() == 0) begin
                $error("unexpected normal %h", out_item);
                errors++;
            end else begin
                want = normals_due.pop_front();
                if (out_item.normal_x !== want.normal_x) begin
                    $error("normal_x expected %0d got %0d", want.normal_x, out_item.normal_x);
                    errors++;
                end
                if (out_item.normal_y !== want.normal_y) begin
                    $error("normal_y expected %0d got %0d", want.normal_y, out_item.normal_y);
                    errors++;
                end
                if (out_item.normal_z !== want.normal_z) begin
                    $error("normal_z expected %0d got %0d", want.normal_z, out_item.normal_z);
                    errors++;
                end
                if (out_item.degenerate !== want.degenerate) begin
                    $error("degenerate expected %0b got %0b", want.degenerate,
                           out_item.degenerate);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    int rx_gap = 0;
    always @(negedge clk) begin
        if (hold_rx) out_ready <= 1'b0;
        else if (rx_gap > 0) begin
            out_ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
                rx_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 600)
                                                      : $urandom_range(1, 5);
        end
    end

    initial begin
        int n;
        face_open = 0;
        face_len = 0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        {fx, fy, fz, px, py, pz} = '0;
        for (int i = 0; i < NVERT; i++) written[i] = 0;

        // directed: extremes, right triangle, degenerate cases, single vertex
        queue_load(0, 16'h0000, 16'h0000, 16'h0000);
        queue_load(4095, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_load(1, 16'h8000, 16'h8000, 16'h8000);
        queue_load(2, 16'h0100, 16'h0000, 16'h0000);
        queue_load(3, 16'h0000, 16'h0100, 16'h0000);
        queue_load(4, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_load(5, 16'h8000, 16'h7FFF, 16'h8000);
        queue_face(3);
        queue_face_vertex(0, 0);
        queue_face_vertex(2, 0);
        queue_load(6, 16'hFFFF, 16'h0001, 16'hFF00);
        queue_face_vertex(3, 1);
        queue_face_vertex(4095, 1);
        queue_face_vertex(4, 0);
        queue_face_vertex(5, 0);
        queue_face_vertex(1, 0);
        queue_face_vertex(4095, 1);
        queue_face_vertex(2, 0);
        queue_face_vertex(2, 1);
        while (pending_items.size() > 0 || normals_due.size() > 0 || in_valid)
            @(posedge clk);

        // overlong face closes itself at the vertex limit
        for (int i = 0; i < MAX_VERTS + 2; i++)
            queue_face_vertex(loaded[$urandom_range(0, loaded.size() - 1)], i == MAX_VERTS + 1);

        // receiver holds off while faces keep arriving
        hold_rx = 1;
        for (int i = 0; i < 12; i++) queue_face($urandom_range(1, 4));
        repeat (6000) @(posedge clk);
        hold_rx = 0;

        n = 0;
        while (n < 1590) begin
            if ($urandom_range(0, 3) == 0 || loaded.size() < 8) begin
                queue_load($urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord());
                n++;
            end else begin
                int len;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 12)
                                                   : $urandom_range(1, 4);
                queue_face(len);
                n += len;
            end
            while (pending_items.size() > 20) @(posedge clk);
        end
        while (pending_items.size() > 0 || in_valid) @(posedge clk);
        while (normals_due.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0) $display("polygon_normal_newell_unit test passed");
        else $display("polygon_normal_newell_unit test failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end
endmodule
